FILE: rtl/core/ctd_pkg.sv
package ctd_pkg;

    localparam int CH_W        = 3;
    localparam int SAMPLE_W    = 15;
    localparam int DROP_W      = 16;
    localparam int CMD_W       = 8;
    localparam int PHASE_W     = 2;
    localparam int STREAK_W    = 2;
    localparam int WARM_W      = 8;
    localparam int THR_W       = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int MASK_W      = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int CHANNELS_DEF = 8;

    localparam logic [WARM_W-1:0]   WARM_RESET = 8'd255;
    localparam logic [WARM_W-1:0]   WARM_LEARN = 8'd240;  // at or above: skipping
    localparam logic [DROP_W-1:0]   DROP_SAT   = 16'd65000;
    localparam logic [STREAK_W-1:0] STREAK_MAX = 2'd3;

    localparam logic [CMD_W-1:0] CMD_CH4_ON  = 8'h03;
    localparam logic [CMD_W-1:0] CMD_CH4_OFF = 8'h30;
    localparam logic [CMD_W-1:0] CMD_CH2_ON  = 8'h02;
    localparam logic [CMD_W-1:0] CMD_CH2_OFF = 8'h20;
    localparam logic [CMD_W-1:0] CMD_CH0_ON  = 8'h01;
    localparam logic [CMD_W-1:0] CMD_CH0_OFF = 8'h10;

    localparam logic [CH_W-1:0] CH_CMD0 = 3'd0;
    localparam logic [CH_W-1:0] CH_CMD2 = 3'd2;
    localparam logic [CH_W-1:0] CH_CMD4 = 3'd4;

    typedef enum logic [PHASE_W-1:0] {
        PH_SKIP   = 2'd0,
        PH_LEARN  = 2'd1,
        PH_DETECT = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_THR  = 2'd0,
        CFG_OFF_THR = 2'd1,
        CFG_WARMUP  = 2'd2,
        CFG_LATCH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // base + (s - base) / 16, quotient truncated toward zero
    function automatic logic [SAMPLE_W-1:0] track(input logic [SAMPLE_W-1:0] base,
                                                  input logic [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W:0] diff;
        logic signed [SAMPLE_W:0] q;
        logic        [SAMPLE_W:0] nb;
        diff = $signed({1'b0, s}) - $signed({1'b0, base});
        q    = diff >>> 4;
        if (diff[SAMPLE_W] && (diff[3:0] != 4'd0)) begin
            q = q + 16'sd1;
        end
        nb = {1'b0, base} + $unsigned(q);
        return nb[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/ctd_div.sv
module ctd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ctd_pkg::DROP_W-1:0]     i_dividend,
    input  logic [ctd_pkg::SAMPLE_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [ctd_pkg::DROP_W-1:0]     o_quotient
);

    localparam int CNT_W = $clog2(ctd_pkg::DROP_W);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic [ctd_pkg::DROP_W-1:0]     r_quo, n_quo;
    logic [ctd_pkg::SAMPLE_W-1:0]   r_rem, n_rem;
    logic [ctd_pkg::SAMPLE_W-1:0]   r_dvs;
    logic [ctd_pkg::DROP_W-1:0]     w_trial;
    logic [ctd_pkg::DROP_W-1:0]     w_sub;
    logic                           w_ge;

    // restoring division, one quotient bit per cycle, MSB first
    assign w_trial = {r_rem, r_quo[ctd_pkg::DROP_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = w_ge ? w_sub[ctd_pkg::SAMPLE_W-1:0] : w_trial[ctd_pkg::SAMPLE_W-1:0];
            n_quo = {r_quo[ctd_pkg::DROP_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ctd_pkg::DROP_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/capacitive_touch_detector.sv
// Capacitive touch detector: per-channel baseline tracking with press/release
// hysteresis and a shared warm-up counter.
// Input stream (s_axis_*): one transaction per sample, tagged with its channel.
// Output stream (m_axis_*): exactly one result transaction per input sample.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data, to be written only while idle;
// the block does not enforce this. Writing the warm-up register reloads the
// warm-up counter. No drop is computed during warm-up or for a sample at or
// above the baseline. A drop ratio comes from a radix-2 serial divider, one
// quotient bit per cycle.
// One sample is in flight at a time; s_axis_tready is high while idle.
// The result sits in an output register, so a new sample is taken while an
// earlier result waits on m_axis_tready; a stalled receiver holds the finished
// item until the output register frees up.
// Reset (synchronous, active low): baselines, streaks and press flags clear,
// thresholds and latch mask clear, warm-up counter loads 255, command byte 0.
module capacitive_touch_detector #(
    parameter int CHANNELS = ctd_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] channel, [17:3] sample, [23:18] zero
    input  logic [ctd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] drop_level, [16] touched, [17] press_event, [25:18] command_code,
    // [27:26] phase, [31:28] zero
    output logic [ctd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [ctd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ctd_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    ctd_pkg::t_state r_state, n_state;

    logic [ctd_pkg::CFG_W-1:0]      r_on_thr;
    logic [ctd_pkg::CFG_W-1:0]      r_off_thr;
    logic [ctd_pkg::MASK_W-1:0]     r_latch_mask;
    logic [ctd_pkg::WARM_W-1:0]     r_warm, n_warm;
    logic                           r_toggle, n_toggle;
    logic [ctd_pkg::CMD_W-1:0]      r_cmd, n_cmd;

    logic [ctd_pkg::SAMPLE_W-1:0]   r_base   [CHANNELS];
    logic                           r_pressed[CHANNELS];
    logic [ctd_pkg::STREAK_W-1:0]   r_streak [CHANNELS];

    logic [ctd_pkg::CH_W-1:0]       r_ch;
    logic [ctd_pkg::SAMPLE_W-1:0]   r_s;
    ctd_pkg::t_phase                r_phase;
    logic                           r_in_range;
    logic                           r_need_div;

    logic                           r_m_valid;
    logic [ctd_pkg::OUT_TDATA_W-1:0] r_m_data;

    logic                           w_accept;
    logic                           w_commit;
    logic [ctd_pkg::CH_W-1:0]       w_in_ch;
    logic [ctd_pkg::SAMPLE_W-1:0]   w_in_s;
    logic                           w_in_range;
    logic [IDX_W-1:0]               w_in_idx;
    logic [ctd_pkg::SAMPLE_W-1:0]   w_in_base;
    ctd_pkg::t_phase                w_phase_now;
    logic                           w_need_div;
    logic [ctd_pkg::SAMPLE_W-1:0]   w_diff;
    logic [ctd_pkg::DROP_W-1:0]     w_dividend;
    logic                           w_div_done;
    logic [ctd_pkg::DROP_W-1:0]     w_quo;

    logic [IDX_W-1:0]               w_idx;
    logic [ctd_pkg::SAMPLE_W-1:0]   w_base;
    logic [ctd_pkg::DROP_W-1:0]     w_drop;
    logic [ctd_pkg::THR_W-1:0]      w_on_byte;
    logic [ctd_pkg::THR_W-1:0]      w_off_byte;
    logic [ctd_pkg::SAMPLE_W-1:0]   n_base;
    logic                           n_pressed;
    logic [ctd_pkg::STREAK_W-1:0]   n_streak;
    logic                           w_event;
    logic                           w_touched;
    logic                           w_bit_sel;
    logic                           w_tog_now;

    // ---- input side ----
    assign w_in_ch    = s_axis_tdata[ctd_pkg::CH_W-1:0];
    assign w_in_s     = s_axis_tdata[ctd_pkg::CH_W +: ctd_pkg::SAMPLE_W];
    assign w_in_range = int'(w_in_ch) < CHANNELS;
    assign w_in_idx   = IDX_W'(w_in_ch);
    assign w_in_base  = r_base[w_in_idx];
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        priority if (r_warm >= ctd_pkg::WARM_LEARN) begin
            w_phase_now = ctd_pkg::PH_SKIP;
        end else if (r_warm != '0) begin
            w_phase_now = ctd_pkg::PH_LEARN;
        end else begin
            w_phase_now = ctd_pkg::PH_DETECT;
        end
    end

    assign w_need_div = w_in_range && (w_phase_now == ctd_pkg::PH_DETECT)
                        && (w_in_s < w_in_base) && (w_in_base != '0);
    assign w_diff     = w_in_base - w_in_s;
    // diff * 128 overflows 16 bits once diff reaches 512
    assign w_dividend = (w_diff[ctd_pkg::SAMPLE_W-1:9] != '0) ? ctd_pkg::DROP_SAT
                        : {w_diff[8:0], 7'b0};

    ctd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && w_need_div),
        .i_dividend (w_dividend),
        .i_divisor  (w_in_base),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // ---- control ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_div ? ctd_pkg::ST_DIV : ctd_pkg::ST_DONE;
                end
            end
            ctd_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = ctd_pkg::ST_DONE;
                end
            end
            ctd_pkg::ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = ctd_pkg::ST_IDLE;
                end
            end
            default: n_state = ctd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ctd_pkg::ST_IDLE);
        w_commit      = (r_state == ctd_pkg::ST_DONE) && (!r_m_valid || m_axis_tready);
    end

    // ---- decision on the held item ----
    assign w_idx      = IDX_W'(r_ch);
    assign w_base     = r_base[w_idx];
    assign w_drop     = r_need_div ? w_quo : '0;
    assign w_on_byte  = r_on_thr[{r_ch, 3'b000} +: ctd_pkg::THR_W];
    assign w_off_byte = r_off_thr[{r_ch, 3'b000} +: ctd_pkg::THR_W];

    always_comb begin
        n_base    = w_base;
        n_pressed = r_pressed[w_idx];
        n_streak  = r_streak[w_idx];
        n_warm    = r_warm;
        n_toggle  = r_toggle;
        n_cmd     = r_cmd;
        w_event   = 1'b0;
        w_bit_sel = 1'b0;
        w_tog_now = 1'b0;
        if (r_in_range) begin
            unique case (r_phase)
                ctd_pkg::PH_SKIP: begin
                    n_warm = r_warm - 1'b1;
                end
                ctd_pkg::PH_LEARN: begin
                    n_base = (w_base == '0) ? r_s : ctd_pkg::track(w_base, r_s);
                    n_warm = r_warm - 1'b1;
                end
                ctd_pkg::PH_DETECT: begin
                    priority if (w_drop < {8'd0, w_off_byte}) begin
                        n_streak  = '0;
                        n_pressed = 1'b0;
                        n_base    = ctd_pkg::track(w_base, r_s);
                    end else if (w_drop > {8'd0, w_on_byte}) begin
                        if (!r_pressed[w_idx] && (r_streak[w_idx] > 2'd1)) begin
                            w_event   = 1'b1;
                            n_pressed = 1'b1;
                            priority if (r_ch == ctd_pkg::CH_CMD4) begin
                                w_bit_sel = r_latch_mask[2];
                            end else if (r_ch == ctd_pkg::CH_CMD2) begin
                                w_bit_sel = r_latch_mask[1];
                            end else begin
                                w_bit_sel = r_latch_mask[0];
                            end
                            w_tog_now = w_bit_sel ? !r_toggle : 1'b1;
                            priority if (r_ch == ctd_pkg::CH_CMD4) begin
                                n_cmd = w_tog_now ? ctd_pkg::CMD_CH4_ON
                                                  : ctd_pkg::CMD_CH4_OFF;
                            end else if (r_ch == ctd_pkg::CH_CMD2) begin
                                n_cmd = w_tog_now ? ctd_pkg::CMD_CH2_ON
                                                  : ctd_pkg::CMD_CH2_OFF;
                            end else if (r_ch == ctd_pkg::CH_CMD0) begin
                                n_cmd = w_tog_now ? ctd_pkg::CMD_CH0_ON
                                                  : ctd_pkg::CMD_CH0_OFF;
                            end else begin
                                n_cmd = r_cmd;
                            end
                            if (w_bit_sel && ((r_ch == ctd_pkg::CH_CMD4)
                                              || (r_ch == ctd_pkg::CH_CMD2)
                                              || (r_ch == ctd_pkg::CH_CMD0))) begin
                                n_toggle = !r_toggle;
                            end
                        end else if (!r_pressed[w_idx]
                                     && (r_streak[w_idx] != ctd_pkg::STREAK_MAX)) begin
                            n_streak = r_streak[w_idx] + 1'b1;
                        end
                    end else begin
                        n_streak = r_streak[w_idx];
                    end
                end
                default: n_warm = r_warm;
            endcase
        end
        w_touched = r_in_range && n_pressed;
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ctd_pkg::ST_IDLE;
            r_on_thr     <= '0;
            r_off_thr    <= '0;
            r_latch_mask <= '0;
            r_warm       <= ctd_pkg::WARM_RESET;
            r_toggle     <= 1'b0;
            r_cmd        <= '0;
            r_m_valid    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_base[i]    <= '0;
                r_pressed[i] <= 1'b0;
                r_streak[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (ctd_pkg::t_cfg_idx'(i_cfg_idx))
                    ctd_pkg::CFG_ON_THR:  r_on_thr     <= i_cfg_data;
                    ctd_pkg::CFG_OFF_THR: r_off_thr    <= i_cfg_data;
                    ctd_pkg::CFG_WARMUP:  r_warm       <= i_cfg_data[ctd_pkg::WARM_W-1:0];
                    ctd_pkg::CFG_LATCH:   r_latch_mask <= i_cfg_data[ctd_pkg::MASK_W-1:0];
                    default:              r_latch_mask <= r_latch_mask;
                endcase
            end
            if (w_commit) begin
                r_m_valid <= 1'b1;
                r_warm    <= n_warm;
                r_toggle  <= n_toggle;
                r_cmd     <= n_cmd;
                if (r_in_range) begin
                    r_base[w_idx]    <= n_base;
                    r_pressed[w_idx] <= n_pressed;
                    r_streak[w_idx]  <= n_streak;
                end
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_ch       <= w_in_ch;
            r_s        <= w_in_s;
            r_phase    <= w_phase_now;
            r_in_range <= w_in_range;
            r_need_div <= w_need_div;
        end
        if (w_commit) begin
            r_m_data <= {4'd0, r_phase, n_cmd, w_event, w_touched, w_drop};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ---- assertions ----
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ctd_pkg::ST_IDLE))
        else $error("accepted sample did not start processing");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ctd_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_event_touched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (!m_axis_tdata[17] || m_axis_tdata[16]))
        else $error("press event without touched flag");

    a_drop_only_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> ((m_axis_tdata[15:0] == '0)
                      || (m_axis_tdata[27:26] == ctd_pkg::PH_DETECT)))
        else $error("nonzero drop outside detection phase");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int SETTLE_CYCLES  = 30;    // beyond the worst-case divider latency
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    // output tdata layout, lowest bits last
    typedef struct packed {
        logic [3:0]                     pad;
        ctd_pkg::t_phase                phase;
        logic [ctd_pkg::CMD_W-1:0]      cmd;
        logic                           press_evt;
        logic                           touched;
        logic [ctd_pkg::DROP_W-1:0]     drop;
    } t_touch_result;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [ctd_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [ctd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               i_cfg_we      = 1'b0;
    ctd_pkg::t_cfg_idx                  i_cfg_idx     = ctd_pkg::CFG_ON_THR;
    logic [ctd_pkg::CFG_W-1:0]          i_cfg_data    = '0;

    // shadow of the block's state and registers
    logic [ctd_pkg::SAMPLE_W-1:0] base_lvl [8] = '{default: '0};
    logic                         pressed  [8] = '{default: 1'b0};
    logic [ctd_pkg::STREAK_W-1:0] streak   [8] = '{default: '0};
    logic [ctd_pkg::WARM_W-1:0]   warm_cnt     = ctd_pkg::WARM_RESET;
    logic                         toggle_q     = 1'b0;
    logic [ctd_pkg::CMD_W-1:0]    cmd_q        = '0;
    logic [ctd_pkg::CFG_W-1:0]    on_thr_q     = '0;
    logic [ctd_pkg::CFG_W-1:0]    off_thr_q    = '0;
    logic [ctd_pkg::MASK_W-1:0]   latch_mask_q = '0;

    t_touch_result expected_touch[$];
    int            chan_level [8];
    int            error_count = 0;
    int            quiet_cycles = 0;
    bit            idle_on = 1'b1;
    bit            hold_rx = 1'b0;

    capacitive_touch_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // baseline moves by a sixteenth of the difference, truncated toward zero
    function automatic logic [ctd_pkg::SAMPLE_W-1:0] follow_baseline(input int b,
                                                                     input int s);
        int nb;
        nb = b + (s - b) / 16;
        return nb[ctd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic void issue_command(input int mask_bit,
                                          input logic [ctd_pkg::CMD_W-1:0] on_code,
                                          input logic [ctd_pkg::CMD_W-1:0] off_code);
        if (latch_mask_q[mask_bit]) begin
            toggle_q = ~toggle_q;
            cmd_q    = toggle_q ? on_code : off_code;
        end else begin
            cmd_q = on_code;
        end
    endfunction

    function automatic t_touch_result predict_touch(input logic [ctd_pkg::CH_W-1:0] ch,
                                                    input logic [ctd_pkg::SAMPLE_W-1:0] smp);
        t_touch_result res;
        int b, s, d, drop;
        res  = '0;
        b    = int'(base_lvl[ch]);
        s    = int'(smp);
        drop = 0;
        if (warm_cnt >= ctd_pkg::WARM_LEARN) begin
            warm_cnt  = warm_cnt - 1'b1;
            res.phase = ctd_pkg::PH_SKIP;
        end else if (warm_cnt != 0) begin
            base_lvl[ch] = (b == 0) ? smp : follow_baseline(b, s);
            warm_cnt     = warm_cnt - 1'b1;
            res.phase    = ctd_pkg::PH_LEARN;
        end else begin
            res.phase = ctd_pkg::PH_DETECT;
            if (s < b && b != 0) begin
                d = (b - s) * 128;
                if (d > 65535) d = int'(ctd_pkg::DROP_SAT);
                drop = d / b;
            end
            if (drop < int'(off_thr_q[ch*8 +: 8])) begin
                streak[ch]   = '0;
                base_lvl[ch] = follow_baseline(b, s);
                pressed[ch]  = 1'b0;
            end else if (drop > int'(on_thr_q[ch*8 +: 8]) && !pressed[ch]) begin
                if (streak[ch] > 1) begin
                    res.press_evt = 1'b1;
                    if (ch == ctd_pkg::CH_CMD4)
                        issue_command(2, ctd_pkg::CMD_CH4_ON, ctd_pkg::CMD_CH4_OFF);
                    if (ch == ctd_pkg::CH_CMD2)
                        issue_command(1, ctd_pkg::CMD_CH2_ON, ctd_pkg::CMD_CH2_OFF);
                    if (ch == ctd_pkg::CH_CMD0)
                        issue_command(0, ctd_pkg::CMD_CH0_ON, ctd_pkg::CMD_CH0_OFF);
                    pressed[ch] = 1'b1;
                end else if (streak[ch] < ctd_pkg::STREAK_MAX) begin
                    streak[ch] = streak[ch] + 1'b1;
                end
            end
        end
        res.drop    = drop[ctd_pkg::DROP_W-1:0];
        res.touched = pressed[ch];
        res.cmd     = cmd_q;
        return res;
    endfunction

    // sample whose drop against the current baseline lands near the target
    function automatic logic [ctd_pkg::SAMPLE_W-1:0] aim_drop(input logic [ctd_pkg::CH_W-1:0] ch,
                                                              input int target);
        int b, s;
        b = int'(base_lvl[ch]);
        s = b - (target * b + 127) / 128;
        if (s < 0) s = 0;
        return s[ctd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic logic [ctd_pkg::SAMPLE_W-1:0] pick_sample(
            input logic [ctd_pkg::CH_W-1:0] ch);
        int r, t, noise, s, on_b, off_b;
        r     = $urandom_range(0, 99);
        on_b  = int'(on_thr_q[ch*8 +: 8]);
        off_b = int'(off_thr_q[ch*8 +: 8]);
        if (r < 10 || (warm_cnt == 0 && base_lvl[ch] == 0)) begin
            return ctd_pkg::SAMPLE_W'($urandom_range(0, 32767));
        end
        if (warm_cnt != 0) begin
            noise = chan_level[ch] / 64 + 1;
            s = chan_level[ch] + int'($urandom_range(0, 2 * noise)) - noise;
        end else begin
            if (r < 50) t = on_b + 1 + int'($urandom_range(0, 15));
            else if (r < 80) t = (off_b > 0) ? int'($urandom_range(0, off_b - 1)) : 0;
            else t = $urandom_range(0, 127);
            if (t > 127) t = 127;
            s = int'(aim_drop(ch, t));
        end
        if (s < 0) s = 0;
        if (s > 32767) s = 32767;
        return s[ctd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic logic [ctd_pkg::CFG_W-1:0] rand_thresholds(input int lo, input int hi);
        logic [ctd_pkg::CFG_W-1:0] v;
        for (int n = 0; n < 8; n++) begin
            if ($urandom_range(0, 99) < 8) v[n*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else v[n*8 +: 8] = 8'($urandom_range(lo, hi));
        end
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input logic [ctd_pkg::CH_W-1:0] ch,
                               input logic [ctd_pkg::SAMPLE_W-1:0] smp);
        int gap;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, smp, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_touch.push_back(predict_touch(ch, smp));
    endtask

    // block must be empty before a register write
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_touch.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input ctd_pkg::t_cfg_idx idx,
                             input logic [ctd_pkg::CFG_W-1:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            ctd_pkg::CFG_ON_THR:  on_thr_q     = data;
            ctd_pkg::CFG_OFF_THR: off_thr_q    = data;
            ctd_pkg::CFG_WARMUP:  warm_cnt     = data[ctd_pkg::WARM_W-1:0];
            ctd_pkg::CFG_LATCH:   latch_mask_q = data[ctd_pkg::MASK_W-1:0];
            default:              latch_mask_q = latch_mask_q;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_touch_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_touch.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_touch.pop_front();
                check_field("drop_level", int'(want.drop), int'(got.drop));
                check_field("touched", int'(want.touched), int'(got.touched));
                check_field("press_event", int'(want.press_evt), int'(got.press_evt));
                check_field("command_code", int'(want.cmd), int'(got.cmd));
                check_field("phase", int'(want.phase), int'(got.phase));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_touch.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                stall_left = 0;
            end else if (!idle_on) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 70) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
            end
        end
    end

    // reset values: warm-up counter at 255, so these all skip
    task automatic test_skip_defaults();
        send_sample(3'd0, 15'd0);
        send_sample(3'd7, 15'h7FFF);
        send_sample(3'd5, 15'h2AAA);
    endtask

    // detection straight away on empty baselines, release tracking from zero
    task automatic test_no_warmup();
        cfg_write(ctd_pkg::CFG_WARMUP, '0);
        cfg_write(ctd_pkg::CFG_ON_THR, '1);
        cfg_write(ctd_pkg::CFG_OFF_THR, '1);
        send_sample(3'd1, 15'd1000);
        send_sample(3'd1, 15'd0);
        send_sample(3'd3, 15'd0);
    endtask

    task automatic test_press_latch();
        cfg_write(ctd_pkg::CFG_ON_THR, {8{8'd20}});
        cfg_write(ctd_pkg::CFG_OFF_THR, {8{8'd10}});
        cfg_write(ctd_pkg::CFG_LATCH, 64'b101);
        cfg_write(ctd_pkg::CFG_WARMUP, 64'd3);
        send_sample(3'd0, 15'd20000);
        send_sample(3'd2, 15'd600);
        send_sample(3'd4, 15'h7FFF);
        // channel 0 toggles on, releases, toggles off
        repeat (3) send_sample(3'd0, aim_drop(3'd0, 60));
        send_sample(3'd0, 15'd20000);
        repeat (3) send_sample(3'd0, aim_drop(3'd0, 60));
        // channel 2 without toggling, drop saturated on a small baseline
        repeat (3) send_sample(3'd2, aim_drop(3'd2, 127));
        send_sample(3'd2, aim_drop(3'd2, 15));
        // full-scale baseline against a zero sample
        send_sample(3'd4, 15'd0);
    endtask

    task automatic test_random_mix(input int n_items,
                                   input logic [ctd_pkg::WARM_W-1:0] warm,
                                   input logic [ctd_pkg::MASK_W-1:0] mask,
                                   input bit idling);
        logic [ctd_pkg::CH_W-1:0] ch;
        cfg_write(ctd_pkg::CFG_ON_THR, rand_thresholds(12, 70));
        cfg_write(ctd_pkg::CFG_OFF_THR, rand_thresholds(0, 12));
        cfg_write(ctd_pkg::CFG_LATCH, ctd_pkg::CFG_W'(mask));
        cfg_write(ctd_pkg::CFG_WARMUP, ctd_pkg::CFG_W'(warm));
        for (int c = 0; c < 8; c++) begin
            chan_level[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(32000, 32767)
                                                          : $urandom_range(150, 30000);
        end
        idle_on = idling;
        repeat (n_items) begin
            // command channels get extra traffic
            ch = $urandom_range(0, 1) ? ctd_pkg::CH_W'($urandom_range(0, 2) * 2)
                                      : ctd_pkg::CH_W'($urandom_range(0, 7));
            send_sample(ch, pick_sample(ch));
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while samples keep coming, input must stall
    task automatic test_output_stall();
        logic [ctd_pkg::CH_W-1:0] ch;
        wait_idle();
        idle_on = 1'b0;
        hold_rx = 1'b1;
        repeat (40) begin
            ch = ctd_pkg::CH_W'($urandom_range(0, 7));
            send_sample(ch, pick_sample(ch));
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_skip_defaults();
        test_no_warmup();
        test_press_latch();
        test_random_mix(230, 8'd255, 3'b111, 1'b1);
        test_random_mix(130, ctd_pkg::WARM_W'($urandom_range(1, 40)), 3'b000, 1'b1);
        test_random_mix(130, ctd_pkg::WARM_W'($urandom_range(1, 40)),
                        ctd_pkg::MASK_W'($urandom_range(0, 7)), 1'b0);
        test_output_stall();
        test_random_mix(130, ctd_pkg::WARM_W'($urandom_range(1, 40)), 3'b101, 1'b1);
        test_random_mix(130, 8'd1, ctd_pkg::MASK_W'($urandom_range(0, 7)), 1'b1);

        wait_idle();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
